@@ hdl/skvt_pkg.sv @@
// Package: sizes, operation codes, status codes and controller commands for the sorted table.
`default_nettype none
package skvt_pkg;
  localparam int unsigned Capacity  = 256;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned IdxBits   = $clog2(Capacity);
  localparam int unsigned CntBits   = $clog2(Capacity + 1);

  localparam logic [3:0] FUNC_INSERT_NEW    = 4'd0;
  localparam logic [3:0] FUNC_INSERT_OR_GET = 4'd1;
  localparam logic [3:0] FUNC_SET_EXISTING  = 4'd2;
  localparam logic [3:0] FUNC_FIND          = 4'd3;
  localparam logic [3:0] FUNC_FIND_PREV     = 4'd4;
  localparam logic [3:0] FUNC_ERASE         = 4'd5;
  localparam logic [3:0] FUNC_ERASE_BY_VAL  = 4'd6;
  localparam logic [3:0] FUNC_EXISTS        = 4'd7;
  localparam logic [3:0] FUNC_CLEAR         = 4'd8;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the request, start search
    logic rd;         // read entry at addr
    logic rd_scan;    // read entry at scan index
    logic srch_step;  // use read data for one search step
    logic scan_step;  // use read data for one scan step
    logic shift_up;   // copy entry i-1 to i
    logic shift_dn;   // copy entry i+1 to i
    logic rd_shift;   // read source of next shift
    logic write_new;  // write request entry at lb
    logic write_val;  // overwrite value at lb
    logic inc;
    logic dec;
    logic clr;
    logic capture;    // latch result fields
    logic [1:0] status;
  } skvt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic hit;
    logic lb_in;      // lb < count
    logic full;
    logic scan_done;
    logic scan_hit;
    logic shift_done;
  } skvt_sts_t;
endpackage
`default_nettype wire

@@ hdl/sorted_key_value_table.sv @@
// Top level: sorted key/value table with stream request and result channels.
// A 256-entry table of unique 32-bit keys in ascending order, each with a 32-bit
// value. One request item in, one result item out; a request is taken only
// when the previous result has been delivered. Sequence: binary-search steps
// (at most 9, each a registered read then a compare), then the lower-bound read
// and decision, then for an insert or erase a move of each shifted entry
// (registered memory read, then write); erase_by_value scans instead of searching.
// Entries above the fill count are never used, so the memories need no clear.
`default_nettype none
module sorted_key_value_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [71:0] s_tdata_i,  // func[3:0], key_in[35:4], value_in[67:36], zero pad
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [87:0] m_tdata_o   // status[1:0], value_out[33:2], key_out[65:34],
                                  // position[74:66], entries_used[83:75], zero pad
);
  import skvt_pkg::*;

  skvt_cmd_t   cmd;
  skvt_sts_t   sts;
  logic [3:0]  func_q;
  logic [1:0]  status;
  logic [31:0] vout, kout;
  logic [8:0]  pos, used;
  logic        busy;

  // opcode held for the whole operation
  always_ff @(posedge clk_i) begin
    if (cmd.load) func_q <= s_tdata_i[3:0];
  end

  skvt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_tvalid_i), .in_ready_o(s_tready_o),
    .out_valid_o(m_tvalid_o), .out_ready_i(m_tready_i),
    .func_i(cmd.load ? s_tdata_i[3:0] : func_q),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  skvt_datapath u_dp (
    .clk_i, .rst_ni,
    .func_i(cmd.load ? s_tdata_i[3:0] : func_q),
    .key_i(s_tdata_i[35:4]), .value_i(s_tdata_i[67:36]),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(status), .value_o(vout), .key_o(kout),
    .position_o(pos), .used_o(used)
  );

  assign m_tdata_o = {4'b0, used, pos, kout, vout, status};

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o) else $error("accept while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !busy) else $error("ready while busy");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= 9'(Capacity)) else $error("count overflow");
endmodule
`default_nettype wire

@@ hdl/skvt_datapath.sv @@
// Datapath: key and value memories, search and scan registers, shift pointer, result registers.
`default_nettype none
module skvt_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  [3:0]                func_i,
  input  wire  [31:0]               key_i,
  input  wire  [31:0]               value_i,
  input  wire  skvt_pkg::skvt_cmd_t cmd_i,
  output skvt_pkg::skvt_sts_t       sts_o,
  output logic [1:0]                status_o,
  output logic [31:0]               value_o,
  output logic [31:0]               key_o,
  output logic [8:0]                position_o,
  output logic [8:0]                used_o
);
  import skvt_pkg::*;

  logic [KeyBits-1:0]   kmem [Capacity];
  logic [ValueBits-1:0] vmem [Capacity];
  logic [KeyBits-1:0]   rk_q;
  logic [ValueBits-1:0] rv_q;

  logic [KeyBits-1:0]   key_q, skey_q;
  logic [ValueBits-1:0] val_q;
  logic [CntBits-1:0]   base_q, len_q, cnt_q, ptr_q;
  logic [IdxBits-1:0]   raddr;
  logic [CntBits-1:0]   half, mid;
  logic                 is_prev, is_del;

  assign half = len_q >> 1;
  assign mid  = base_q + half;
  assign is_del = (func_i == FUNC_ERASE) || (func_i == FUNC_ERASE_BY_VAL);

  always_comb begin
    raddr = mid[IdxBits-1:0];
    if (cmd_i.rd_scan) raddr = ptr_q[IdxBits-1:0];
    else if (cmd_i.rd_shift) begin
      if (is_del) raddr = IdxBits'(ptr_q + 1'b1);
      else raddr = IdxBits'(ptr_q - 1'b1);
    end else if (!cmd_i.rd) raddr = base_q[IdxBits-1:0];
  end

  // registered memory read; writes for shift use the read data of the previous cycle
  always_ff @(posedge clk_i) begin
    rk_q <= kmem[raddr];
    rv_q <= vmem[raddr];
    if (cmd_i.shift_up || cmd_i.shift_dn) begin
      kmem[ptr_q[IdxBits-1:0]] <= rk_q;
      vmem[ptr_q[IdxBits-1:0]] <= rv_q;
    end else if (cmd_i.write_new) begin
      kmem[base_q[IdxBits-1:0]] <= key_q;
      vmem[base_q[IdxBits-1:0]] <= val_q;
    end else if (cmd_i.write_val) begin
      vmem[base_q[IdxBits-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr) begin
      cnt_q <= '0;
    end else if (cmd_i.inc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.dec) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign is_prev = (func_i == FUNC_FIND_PREV);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= key_i[KeyBits-1:0];
      skey_q <= is_prev ? key_i[KeyBits-1:0] - 1'b1 : key_i[KeyBits-1:0];
      val_q  <= value_i[ValueBits-1:0];
      base_q <= '0;
      len_q  <= cnt_q;
      ptr_q  <= '0;
    end else if (cmd_i.srch_step) begin
      if (rk_q < skey_q) begin
        base_q <= mid + 1'b1;
        len_q  <= len_q - half - 1'b1;
      end else begin
        len_q <= half;
      end
    end else if (cmd_i.scan_step) begin
      if (!(rv_q == val_q)) ptr_q <= ptr_q + 1'b1;
    end else if (cmd_i.capture && sts_o.lb_in && !is_del) begin
      ptr_q <= cnt_q; // start point of an insert shift
    end else if (cmd_i.capture && is_del) begin
      if (func_i == FUNC_ERASE) ptr_q <= base_q;
      base_q <= (func_i == FUNC_ERASE) ? base_q : ptr_q;
    end else if (cmd_i.shift_up) begin
      ptr_q <= ptr_q - 1'b1;
    end else if (cmd_i.shift_dn) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  assign sts_o.srch_done  = (len_q == '0);
  assign sts_o.lb_in      = (base_q < cnt_q);
  assign sts_o.hit        = sts_o.lb_in && (rk_q == key_q);
  assign sts_o.full       = (cnt_q == CntBits'(Capacity));
  assign sts_o.scan_done  = (ptr_q >= cnt_q);
  assign sts_o.scan_hit   = (rv_q == val_q);
  assign sts_o.shift_done = is_del ? (CntBits'(ptr_q + 1'b1) >= cnt_q) : (ptr_q <= base_q);

  // result capture; rk_q/rv_q hold the entry at lb (or at the scan index)
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_o <= cmd_i.status;
      if (func_i >= FUNC_CLEAR) position_o <= '0;
      else if (func_i == FUNC_ERASE_BY_VAL) position_o <= 9'(ptr_q);
      else position_o <= 9'(base_q);
      if (!(cmd_i.status == ST_DONE || cmd_i.status == ST_PRESENT)) begin
        value_o <= '0;
        key_o   <= '0;
      end else if (func_i == FUNC_INSERT_NEW || func_i == FUNC_INSERT_OR_GET) begin
        value_o <= 32'(cmd_i.status == ST_PRESENT ? rv_q : val_q);
        key_o   <= 32'(key_q);
      end else if (func_i == FUNC_SET_EXISTING) begin
        value_o <= 32'(val_q);
        key_o   <= 32'(key_q);
      end else if (func_i <= FUNC_EXISTS) begin
        value_o <= 32'(rv_q);
        key_o   <= 32'(rk_q);
      end else begin
        value_o <= '0;
        key_o   <= '0;
      end
    end
  end

  assign used_o = 9'(cnt_q);
endmodule
`default_nettype wire

@@ hdl/skvt_ctrl.sv @@
// Controller: sequences search, scan, shift and writeback for each request item.
`default_nettype none
module skvt_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire  [3:0]                func_i,
  input  wire  skvt_pkg::skvt_sts_t sts_i,
  output skvt_pkg::skvt_cmd_t       cmd_o,
  output logic                      busy_o
);
  import skvt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;  // read issued
  localparam logic [3:0] S_SUSE  = 4'd2;  // read data valid
  localparam logic [3:0] S_LBRD  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_SCRD  = 4'd5;
  localparam logic [3:0] S_SCUSE = 4'd6;
  localparam logic [3:0] S_SHRD  = 4'd7;
  localparam logic [3:0] S_SHWR  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [3:0] func_q;
  logic       hold_ins, hold_del, hold_set;
  logic       ins_q, del_q, set_q, ins_d, del_d, set_d;

  assign func_q = func_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ins_d = ins_q; del_d = del_q; set_d = set_q;
    hold_ins = 1'b0; hold_del = 1'b0; hold_set = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !out_valid_o) begin
        cmd_o.load = 1'b1;
        ins_d = 1'b0; del_d = 1'b0; set_d = 1'b0;
        state_d = (func_i == FUNC_ERASE_BY_VAL) ? S_SCRD : S_SRCH;
      end
      S_SRCH: begin
        if (sts_i.srch_done) state_d = S_LBRD;
        else begin cmd_o.rd = 1'b1; state_d = S_SUSE; end
      end
      S_SUSE: begin cmd_o.srch_step = 1'b1; state_d = S_SRCH; end
      S_LBRD: state_d = S_DEC;   // entry at lb read in this cycle
      S_DEC: begin
        cmd_o.capture = 1'b1;
        cmd_o.status = ST_DONE;
        state_d = S_OUT;
        case (func_q)
          FUNC_INSERT_NEW, FUNC_INSERT_OR_GET: begin
            if (sts_i.hit) cmd_o.status = ST_PRESENT;
            else if (sts_i.full) cmd_o.status = ST_FULL;
            else begin ins_d = 1'b1; state_d = S_SHRD; end
          end
          FUNC_SET_EXISTING: begin
            if (sts_i.hit) begin set_d = 1'b1; state_d = S_FIN; end
            else cmd_o.status = ST_NOT_FOUND;
          end
          FUNC_FIND, FUNC_EXISTS, FUNC_ERASE: begin
            if (!sts_i.hit) cmd_o.status = ST_NOT_FOUND;
            else if (func_q == FUNC_ERASE) begin del_d = 1'b1; state_d = S_SHRD; end
          end
          FUNC_FIND_PREV: if (!sts_i.lb_in) cmd_o.status = ST_NOT_FOUND;
          FUNC_CLEAR: cmd_o.clr = 1'b1;
          default: ;
        endcase
      end
      S_SCRD: begin
        if (sts_i.scan_done) begin
          cmd_o.capture = 1'b1; cmd_o.status = ST_NOT_FOUND; state_d = S_OUT;
        end else begin cmd_o.rd_scan = 1'b1; state_d = S_SCUSE; end
      end
      S_SCUSE: begin
        if (sts_i.scan_hit) begin
          cmd_o.capture = 1'b1; cmd_o.status = ST_DONE;
          del_d = 1'b1; state_d = S_SHRD;
        end else begin cmd_o.scan_step = 1'b1; state_d = S_SCRD; end
      end
      S_SHRD: begin
        if (sts_i.shift_done) state_d = S_FIN;
        else begin cmd_o.rd_shift = 1'b1; state_d = S_SHWR; end
      end
      S_SHWR: begin
        cmd_o.shift_up = ins_q; cmd_o.shift_dn = del_q; state_d = S_SHRD;
      end
      S_FIN: begin
        hold_ins = ins_q; hold_del = del_q; hold_set = set_q;
        cmd_o.write_new = hold_ins; cmd_o.inc = hold_ins;
        cmd_o.dec = hold_del; cmd_o.write_val = hold_set;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ins_q <= 1'b0; del_q <= 1'b0; set_q <= 1'b0;
    end else begin
      state_q <= state_d; ins_q <= ins_d; del_q <= del_d; set_q <= set_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign busy_o      = (state_q != S_IDLE);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.shift_up && cmd_o.shift_dn)) else $error("shift both ways");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_one_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.inc, cmd_o.dec, cmd_o.clr}) <= 1) else $error("count conflict");
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the sorted key/value table: directed and random stream traffic, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import skvt_pkg::*;

  // packed from the top bit down, so status lands in the lowest bits
  typedef struct packed {
    logic [8:0]  entries_used;
    logic [8:0]  position;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [1:0]  status;
  } table_result_t;

  // Scoreboard: holds a model of the table and the queue of expected results.
  class table_scoreboard;
    logic [31:0] keys[$];
    logic [31:0] vals[$];
    table_result_t pending[$];
    int errors;
    int checked;

    function int lower_idx(logic [31:0] k);
      int base;
      int len;
      int half;
      base = 0;
      len = keys.size();
      while (len > 0) begin
        half = len >> 1;
        if (keys[base + half] < k) begin
          base = base + half + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      return base;
    endfunction

    function void note_request(logic [3:0] op, logic [31:0] k, logic [31:0] v);
      table_result_t r;
      int lb;
      int i;
      bit hit;
      r = '0;
      lb = lower_idx(k);
      hit = (lb < keys.size()) && (keys[lb] == k);
      case (op)
        FUNC_INSERT_NEW, FUNC_INSERT_OR_GET: begin
          r.position = 9'(lb);
          if (hit) begin
            r.status = ST_PRESENT; r.value_out = vals[lb]; r.key_out = k;
          end else if (keys.size() >= Capacity) begin
            r.status = ST_FULL;
          end else begin
            keys.insert(lb, k); vals.insert(lb, v);
            r.status = ST_DONE; r.value_out = v; r.key_out = k;
          end
        end
        FUNC_SET_EXISTING: begin
          r.position = 9'(lb);
          if (hit) begin
            vals[lb] = v; r.value_out = v; r.key_out = k;
          end else r.status = ST_NOT_FOUND;
        end
        FUNC_FIND, FUNC_EXISTS: begin
          r.position = 9'(lb);
          if (hit) begin
            r.value_out = vals[lb]; r.key_out = k;
          end else r.status = ST_NOT_FOUND;
        end
        FUNC_FIND_PREV: begin
          lb = lower_idx(k - 32'd1);
          r.position = 9'(lb);
          if (lb < keys.size()) begin
            r.value_out = vals[lb]; r.key_out = keys[lb];
          end else r.status = ST_NOT_FOUND;
        end
        FUNC_ERASE: begin
          r.position = 9'(lb);
          if (hit) begin
            r.value_out = vals[lb]; r.key_out = k;
            keys.delete(lb); vals.delete(lb);
          end else r.status = ST_NOT_FOUND;
        end
        FUNC_ERASE_BY_VAL: begin
          for (i = 0; i < vals.size(); i++) if (vals[i] == v) break;
          r.position = 9'(i);
          if (i < vals.size()) begin
            r.value_out = vals[i]; r.key_out = keys[i];
            keys.delete(i); vals.delete(i);
          end else r.status = ST_NOT_FOUND;
        end
        FUNC_CLEAR: begin
          keys.delete(); vals.delete();
        end
        default: ;
      endcase
      r.entries_used = 9'(keys.size());
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status); errors++;
      end
      if (got.value_out !== exp.value_out) begin
        $display("%0t: value_out exp %h got %h", $time, exp.value_out, got.value_out);
        errors++;
      end
      if (got.key_out !== exp.key_out) begin
        $display("%0t: key_out exp %h got %h", $time, exp.key_out, got.key_out); errors++;
      end
      if (got.position !== exp.position) begin
        $display("%0t: position exp %0d got %0d", $time, exp.position, got.position);
        errors++;
      end
      if (got.entries_used !== exp.entries_used) begin
        $display("%0t: entries_used exp %0d got %0d", $time, exp.entries_used,
                 got.entries_used);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [71:0] s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [87:0] m_tdata_o;

  table_scoreboard board;
  bit calm;         // no idling in the tail of the run
  bit stim_done;
  int sent;

  sorted_key_value_table dut (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Send one request; a random gap before it unless in the calm tail.
  task automatic send_req(logic [3:0] op, logic [31:0] k, logic [31:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {4'd0, v, k, op};
    do @(posedge clk_i); while (!s_tready_o);
    board.note_request(op, k, v);
    sent++;
  endtask

  task automatic drop_valid();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Keys drawn mostly from a small pool so hits, duplicates and erases occur.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 63) * 32'h0400_0001;
    endcase
  endfunction

  // Receiver with random stall bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) board.check_result(m_tdata_o[83:0]);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
    end
  end

  initial begin
    int i;
    int mode;
    logic [3:0] op;
    board = new();
    calm = 1'b0;
    stim_done = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    m_tready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table lookups, extremes, every opcode, unused codes.
    send_req(FUNC_FIND, 32'h0, 32'h0);
    send_req(FUNC_FIND_PREV, 32'h0, 32'h0);
    send_req(FUNC_ERASE_BY_VAL, 32'h0, 32'h0);
    send_req(FUNC_INSERT_NEW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_INSERT_NEW, 32'h0, 32'h0);
    send_req(FUNC_INSERT_OR_GET, 32'h8000_0000, 32'h5A5A_A5A5);
    send_req(FUNC_INSERT_NEW, 32'h0, 32'h1234_5678);     // duplicate key
    send_req(FUNC_INSERT_OR_GET, 32'hFFFF_FFFF, 32'h1);
    send_req(FUNC_FIND_PREV, 32'h0, 32'h0);              // wraps to largest key
    send_req(FUNC_FIND_PREV, 32'h8000_0001, 32'h0);
    send_req(FUNC_SET_EXISTING, 32'h8000_0000, 32'hA5A5_5A5A);
    send_req(FUNC_SET_EXISTING, 32'h7, 32'h7);
    send_req(FUNC_EXISTS, 32'h8000_0000, 32'h0);
    send_req(FUNC_EXISTS, 32'h3, 32'h0);
    send_req(FUNC_ERASE, 32'h0, 32'h0);
    send_req(FUNC_ERASE, 32'h0, 32'h0);
    send_req(FUNC_ERASE_BY_VAL, 32'h0, 32'hFFFF_FFFF);
    send_req(4'd9, 32'h1, 32'h1);
    send_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_CLEAR, 32'h0, 32'h0);

    // Fill to capacity, hit the full case, then drain by erasing by value.
    for (i = 0; i < Capacity; i++)
      send_req(FUNC_INSERT_NEW, $urandom, $urandom_range(0, 31));
    send_req(FUNC_INSERT_NEW, 32'h1357_9BDF, 32'h1);
    send_req(FUNC_INSERT_OR_GET, $urandom, 32'h2);
    for (i = 0; i < 40; i++) send_req(FUNC_ERASE_BY_VAL, 32'h0, $urandom_range(0, 31));

    // Random phase: structured mix over a small key pool.
    for (i = 0; i < 90; i++) begin
      if (i == 70) calm = 1'b1;
      mode = $urandom_range(0, 99);
      if (mode < 30) op = 4'(FUNC_INSERT_NEW + $urandom_range(0, 1));
      else if (mode < 98) op = 4'($urandom_range(2, 7));
      else if (mode < 99) op = FUNC_CLEAR;
      else op = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 1)) send_req(op, pick_key(), $urandom_range(0, 15));
      else send_req(op, pick_key(), $urandom);
    end
    drop_valid();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, incl. full table and wrap cases.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Bound for ~410 items at a 4 ns clock period plus stalls, taken many times over.
  initial begin
    #20_000_000;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
